/* src/apf_pkg.sv */
// Shared types, constants and helpers for the IPv4 prefix access filter.
package apf_pkg;

    localparam int NUM_RULES = 16;
    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 32;
    localparam int POLICY_W  = 2;
    localparam int OP_W      = 2;
    localparam int IDX_W     = 4;
    localparam int PLEN_W    = 6;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 2;

    localparam logic [PADDR_W-1:0] ADDR_POLICY = '0;

    typedef enum logic [OP_W-1:0] {
        OP_CHECK = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [POLICY_W-1:0] {
        POL_ALLOW = 2'd0,
        POL_DENY  = 2'd1
    } t_policy;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] network;
        logic [ADDR_W-1:0] mask;
        logic              is_deny;
        logic              enable;
    } t_rule;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic              hit_allow;
        logic              hit_deny;
    } t_token;

    function automatic logic [ADDR_W-1:0] mask_from_prefix(input logic [PLEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        begin
            if (len >= PLEN_W'(ADDR_W)) begin
                m = '1;
            end else begin
                m = ~({ADDR_W{1'b1}} >> len);
            end
            return m;
        end
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        begin
            return (v == '1) ? v : v + CNT_W'(1);
        end
    endfunction

endpackage

/* src/apf_cell.sv */
// One rule cell: holds a rule and folds its match into the passing token.
module apf_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  apf_pkg::t_rule i_wr_rule,
    input  apf_pkg::t_token i_tok,
    output apf_pkg::t_token o_tok
);
    import apf_pkg::*;

    t_rule  r_rule;
    t_token r_tok;
    t_token n_tok;
    logic   w_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule <= '0;
        end else if (i_wr_en) begin
            r_rule <= i_wr_rule;
        end
    end

    assign w_match = r_rule.enable &&
                     ((i_tok.addr & r_rule.mask) == (r_rule.network & r_rule.mask));

    always_comb begin
        n_tok           = i_tok;
        n_tok.hit_allow = i_tok.hit_allow | (w_match & ~r_rule.is_deny);
        n_tok.hit_deny  = i_tok.hit_deny  | (w_match &  r_rule.is_deny);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

/* src/ip_prefix_access_filter.sv */
// Top level of the IPv4 prefix access filter: command port, rule cell chain, counters.
// An item is taken when start is high and busy is low. Rule writes, counter clears and
// unused op codes give their result strobe (o_valid) in the cycle after acceptance and
// never raise busy, so such items can be issued every cycle. An address check walks a
// chain of NUM_RULES rule cells, one cell per cycle, and its result is registered behind
// the last cell; busy stays high until that result shows, so no new item is taken while
// a check is still passing along the chain of cells. Every result is held for one
// cycle only and must be taken then; there is no way to stall it. The default policy
// register sits at byte address 0 of the configuration port and should only be written
// while busy is low and no result is pending.
module ip_prefix_access_filter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [apf_pkg::OP_W-1:0]     i_op,
    input  logic [apf_pkg::ADDR_W-1:0]   i_address,
    input  logic [apf_pkg::IDX_W-1:0]    i_rule_index,
    input  logic                         i_rule_is_deny,
    input  logic                         i_rule_enable,
    input  logic [apf_pkg::ADDR_W-1:0]   i_rule_network,
    input  logic [apf_pkg::ADDR_W-1:0]   i_rule_netmask,
    input  logic                         i_mask_is_prefix,
    input  logic [apf_pkg::PLEN_W-1:0]   i_prefix_len,
    output logic                         o_valid,
    output logic                         o_granted,
    output logic [apf_pkg::CNT_W-1:0]    o_granted_count,
    output logic [apf_pkg::CNT_W-1:0]    o_denied_count,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [apf_pkg::PADDR_W-1:0]  paddr,
    input  logic [apf_pkg::DATA_W-1:0]   pwdata,
    output logic [apf_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import apf_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [POLICY_W-1:0]   r_policy;
    logic [CNT_W-1:0]      r_grant_cnt;
    logic [CNT_W-1:0]      r_refuse_cnt;
    logic                  r_valid;
    logic                  r_granted;
    logic                  w_accept;
    logic                  w_access;
    t_rule                 w_wr_rule;
    t_token                w_tok [0:NUM_RULES];
    t_token                w_last;

    assign pready   = 1'b1;
    assign prdata   = {{(DATA_W-POLICY_W){1'b0}}, r_policy};
    assign busy     = (r_state == ST_SCAN);
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_ALLOW;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_POLICY)) begin
            r_policy <= pwdata[POLICY_W-1:0];
        end
    end

    // rule write payload
    always_comb begin
        w_wr_rule.network = i_rule_network;
        w_wr_rule.mask    = i_mask_is_prefix ? mask_from_prefix(i_prefix_len) : i_rule_netmask;
        w_wr_rule.is_deny = i_rule_is_deny;
        w_wr_rule.enable  = i_rule_enable;
    end

    always_comb begin
        w_tok[0].valid     = w_accept && (i_op == OP_CHECK);
        w_tok[0].addr      = i_address;
        w_tok[0].hit_allow = 1'b0;
        w_tok[0].hit_deny  = 1'b0;
    end

    for (genvar k = 0; k < NUM_RULES; k++) begin : g_cell
        logic w_wr_en;
        assign w_wr_en = w_accept && (i_op == OP_WRITE) && (32'(i_rule_index) == k);
        apf_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (w_wr_en),
            .i_wr_rule (w_wr_rule),
            .i_tok     (w_tok[k]),
            .o_tok     (w_tok[k+1])
        );
    end

    assign w_last = w_tok[NUM_RULES];

    always_comb begin
        case (r_policy)
            POL_ALLOW: w_access = !w_last.hit_deny;
            POL_DENY:  w_access = w_last.hit_allow;
            default:   w_access = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept && (i_op == OP_CHECK)) n_state = ST_SCAN;
            ST_SCAN: if (w_last.valid) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_granted    <= 1'b0;
            r_grant_cnt  <= '0;
            r_refuse_cnt <= '0;
        end else begin
            r_valid <= 1'b0;
            if (w_last.valid) begin
                r_valid   <= 1'b1;
                r_granted <= w_access;
                if (w_access) begin
                    r_grant_cnt <= sat_inc(r_grant_cnt);
                end else begin
                    r_refuse_cnt <= sat_inc(r_refuse_cnt);
                end
            end else if (w_accept && (i_op != OP_CHECK)) begin
                r_valid   <= 1'b1;
                r_granted <= 1'b0;
                if (i_op == OP_CLEAR) begin
                    r_grant_cnt  <= '0;
                    r_refuse_cnt <= '0;
                end
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_granted       = r_granted;
    assign o_granted_count = r_grant_cnt;
    assign o_denied_count  = r_refuse_cnt;

endmodule

/* src/apf_checker.sv */
// Port-level checks for the IPv4 prefix access filter, bound to the top level.
module apf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [apf_pkg::OP_W-1:0]    i_op,
    input logic                        o_valid,
    input logic                        o_granted,
    input logic [apf_pkg::CNT_W-1:0]   o_granted_count,
    input logic [apf_pkg::CNT_W-1:0]   o_denied_count
);
    import apf_pkg::*;

    a_check_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_CHECK) |=> (busy && !o_valid))
        else $error("check item did not raise busy");

    a_cmd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op != OP_CHECK) |=> (o_valid && !o_granted && !busy))
        else $error("command item result missing or granted");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_CLEAR) |=>
            (o_granted_count == '0 && o_denied_count == '0))
        else $error("counters not cleared");

    a_busy_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid)
        else $error("result strobe while busy");

    a_grant_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_granted) |-> (o_granted_count != '0))
        else $error("granted check with zero grant count");

endmodule

bind ip_prefix_access_filter apf_checker u_apf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_op            (i_op),
    .o_valid         (o_valid),
    .o_granted       (o_granted),
    .o_granted_count (o_granted_count),
    .o_denied_count  (o_denied_count)
);

/* verif/tb.sv */
// Self-checking testbench for the IPv4 prefix access filter: random and directed items.
module tb;
    import apf_pkg::*;

    localparam logic [OP_W-1:0]     OP_UNUSED   = 2'd3;
    localparam logic [POLICY_W-1:0] POL_BAD2    = 2'd2;
    localparam logic [POLICY_W-1:0] POL_BAD3    = 2'd3;
    localparam int                  CYCLE_LIMIT = 400000;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic [IDX_W-1:0]  index;
        logic              is_deny;
        logic              enable;
        logic [ADDR_W-1:0] network;
        logic [ADDR_W-1:0] netmask;
        logic              mask_is_prefix;
        logic [PLEN_W-1:0] prefix_len;
    } t_acl_cmd;

    typedef struct {
        logic             granted;
        logic [CNT_W-1:0] grants;
        logic [CNT_W-1:0] refusals;
    } t_verdict;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_op = '0;
    logic [ADDR_W-1:0]   i_address = '0;
    logic [IDX_W-1:0]    i_rule_index = '0;
    logic                i_rule_is_deny = 1'b0;
    logic                i_rule_enable = 1'b0;
    logic [ADDR_W-1:0]   i_rule_network = '0;
    logic [ADDR_W-1:0]   i_rule_netmask = '0;
    logic                i_mask_is_prefix = 1'b0;
    logic [PLEN_W-1:0]   i_prefix_len = '0;
    logic                o_valid;
    logic                o_granted;
    logic [CNT_W-1:0]    o_granted_count;
    logic [CNT_W-1:0]    o_denied_count;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    t_acl_cmd            pending_cmds[$];
    t_verdict            verdicts_due[$];
    int                  gap_pct = 32;
    logic                hold_sender = 1'b0;
    int                  fault_count = 0;
    int                  cycle_count = 0;

    // predictor state
    logic [ADDR_W-1:0]   rule_net[NUM_RULES];
    logic [ADDR_W-1:0]   rule_mask[NUM_RULES];
    logic                rule_deny[NUM_RULES];
    logic                rule_on[NUM_RULES];
    logic [CNT_W-1:0]    grant_tally;
    logic [CNT_W-1:0]    refuse_tally;
    logic [POLICY_W-1:0] policy_q;

    // generator shadow of the table, used to aim addresses at rules
    logic [ADDR_W-1:0]   aim_net[NUM_RULES];
    logic [ADDR_W-1:0]   aim_mask[NUM_RULES];

    ip_prefix_access_filter u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_address        (i_address),
        .i_rule_index     (i_rule_index),
        .i_rule_is_deny   (i_rule_is_deny),
        .i_rule_enable    (i_rule_enable),
        .i_rule_network   (i_rule_network),
        .i_rule_netmask   (i_rule_netmask),
        .i_mask_is_prefix (i_mask_is_prefix),
        .i_prefix_len     (i_prefix_len),
        .o_valid          (o_valid),
        .o_granted        (o_granted),
        .o_granted_count  (o_granted_count),
        .o_denied_count   (o_denied_count),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [ADDR_W-1:0] prefix_mask(logic [PLEN_W-1:0] len);
        if (len >= ADDR_W) begin
            return '1;
        end else if (len == 0) begin
            return '0;
        end
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function automatic void filter_step(t_acl_cmd c);
        t_verdict v;
        logic     hit_allow;
        logic     hit_deny;
        logic     ok;
        v.granted = 1'b0;
        hit_allow = 1'b0;
        hit_deny  = 1'b0;
        case (c.op)
            OP_CHECK: begin
                for (int k = 0; k < NUM_RULES; k++) begin
                    if (rule_on[k] &&
                        (c.address & rule_mask[k]) == (rule_net[k] & rule_mask[k])) begin
                        if (rule_deny[k]) hit_deny = 1'b1;
                        else hit_allow = 1'b1;
                    end
                end
                if (policy_q == POL_ALLOW) ok = !hit_deny;
                else if (policy_q == POL_DENY) ok = hit_allow;
                else ok = 1'b0;
                if (ok) begin
                    v.granted   = 1'b1;
                    grant_tally = bump(grant_tally);
                end else begin
                    refuse_tally = bump(refuse_tally);
                end
            end
            OP_WRITE: begin
                if (c.index < NUM_RULES) begin
                    rule_net[c.index]  = c.network;
                    rule_mask[c.index] = c.mask_is_prefix ? prefix_mask(c.prefix_len)
                                                          : c.netmask;
                    rule_deny[c.index] = c.is_deny;
                    rule_on[c.index]   = c.enable;
                end
            end
            OP_CLEAR: begin
                grant_tally  = '0;
                refuse_tally = '0;
            end
            default: ;
        endcase
        v.grants   = grant_tally;
        v.refusals = refuse_tally;
        verdicts_due.push_back(v);
    endfunction

    task automatic flag(string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        fault_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                filter_step(pending_cmds.pop_front());
            end
            if (start && busy) begin
                // item held until taken
            end else if (pending_cmds.size() != 0 && !hold_sender &&
                         $urandom_range(99) >= gap_pct) begin
                start            <= 1'b1;
                i_op             <= pending_cmds[0].op;
                i_address        <= pending_cmds[0].address;
                i_rule_index     <= pending_cmds[0].index;
                i_rule_is_deny   <= pending_cmds[0].is_deny;
                i_rule_enable    <= pending_cmds[0].enable;
                i_rule_network   <= pending_cmds[0].network;
                i_rule_netmask   <= pending_cmds[0].netmask;
                i_mask_is_prefix <= pending_cmds[0].mask_is_prefix;
                i_prefix_len     <= pending_cmds[0].prefix_len;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_verdict want;
        if (i_rst_n && o_valid) begin
            if (verdicts_due.size() == 0) begin
                flag("result with no item outstanding");
            end else begin
                want = verdicts_due.pop_front();
                if (o_granted !== want.granted)
                    flag($sformatf("granted %b, want %b", o_granted, want.granted));
                if (o_granted_count !== want.grants)
                    flag($sformatf("granted_count %0d, want %0d",
                                   o_granted_count, want.grants));
                if (o_denied_count !== want.refusals)
                    flag($sformatf("denied_count %0d, want %0d",
                                   o_denied_count, want.refusals));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic t_acl_cmd noise_cmd(logic [OP_W-1:0] op);
        t_acl_cmd c;
        c.op             = op;
        c.address        = $urandom;
        c.index          = IDX_W'($urandom);
        c.is_deny        = 1'($urandom);
        c.enable         = 1'($urandom);
        c.network        = $urandom;
        c.netmask        = $urandom;
        c.mask_is_prefix = 1'($urandom);
        c.prefix_len     = PLEN_W'($urandom);
        return c;
    endfunction

    task automatic push_op(logic [OP_W-1:0] op);
        pending_cmds.push_back(noise_cmd(op));
    endtask

    task automatic push_check(logic [ADDR_W-1:0] addr);
        t_acl_cmd c;
        c = noise_cmd(OP_CHECK);
        c.address = addr;
        pending_cmds.push_back(c);
    endtask

    task automatic push_rule(logic [IDX_W-1:0] idx, logic deny, logic en,
                             logic [ADDR_W-1:0] net, logic use_prefix,
                             logic [PLEN_W-1:0] plen, logic [ADDR_W-1:0] mask);
        t_acl_cmd c;
        c = noise_cmd(OP_WRITE);
        c.index          = idx;
        c.is_deny        = deny;
        c.enable         = en;
        c.network        = net;
        c.mask_is_prefix = use_prefix;
        c.prefix_len     = plen;
        c.netmask        = mask;
        aim_net[idx]  = net;
        aim_mask[idx] = use_prefix ? prefix_mask(plen) : mask;
        pending_cmds.push_back(c);
    endtask

    task automatic settle();
        while (pending_cmds.size() != 0 || verdicts_due.size() != 0 || busy || start)
            @(posedge i_clk);
        repeat (NUM_RULES + 2) @(posedge i_clk);
    endtask

    task automatic set_policy(logic [POLICY_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_POLICY;
        pwdata  <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        policy_q = val;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== DATA_W'(val))
            flag($sformatf("policy read back %0h, want %0h", prdata, val));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_random(int count);
        int                r;
        int                k;
        logic [ADDR_W-1:0] addr;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 55) begin
                if ($urandom_range(99) < 65) begin
                    k = $urandom_range(NUM_RULES - 1);
                    addr = (aim_net[k] & aim_mask[k]) | ($urandom & ~aim_mask[k]);
                    if ($urandom_range(3) == 0) addr ^= 32'd1 << $urandom_range(31);
                end else begin
                    addr = $urandom;
                end
                push_check(addr);
            end else if (r < 88) begin
                push_rule(IDX_W'($urandom), 1'($urandom), $urandom_range(99) < 80,
                          $urandom, $urandom_range(99) < 70,
                          PLEN_W'(($urandom_range(99) < 85) ? $urandom_range(32)
                                                            : $urandom_range(63, 33)),
                          $urandom);
            end else if (r < 94) begin
                push_op(OP_CLEAR);
            end else begin
                push_op(OP_UNUSED);
            end
        end
    endtask

    initial begin
        for (int k = 0; k < NUM_RULES; k++) begin
            rule_net[k]  = '0;
            rule_mask[k] = '0;
            rule_deny[k] = 1'b0;
            rule_on[k]   = 1'b0;
            aim_net[k]   = '0;
            aim_mask[k]  = '0;
        end
        grant_tally  = '0;
        refuse_tally = '0;
        policy_q     = POL_ALLOW;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset policy (allow)
        push_check('0);
        push_check('1);
        push_rule(4'd0, 1'b1, 1'b1, 32'hC0A8_0000, 1'b1, 6'd16, '0);
        push_check(32'hC0A8_1234);
        push_check(32'hC0A9_0000);
        push_rule(4'd1, 1'b1, 1'b1, 32'h0A00_0001, 1'b1, 6'd63, '0);
        push_check(32'h0A00_0001);
        push_check(32'h0A00_0000);
        push_rule(4'd2, 1'b1, 1'b0, '0, 1'b1, 6'd0, '0);
        push_check(32'h1234_5678);
        push_rule(4'd3, 1'b1, 1'b1, 32'h0505_0505, 1'b0, 6'd40, 32'h0F0F_0F0F);
        push_check(32'hF5A5_C5E5);
        push_op(OP_UNUSED);
        push_op(OP_CLEAR);
        push_check(32'hF5A5_C5E4);
        settle();

        set_policy(POL_DENY);
        push_rule(4'd15, 1'b0, 1'b1, '1, 1'b1, 6'd0, '0);
        push_check('0);
        push_rule(4'd15, 1'b0, 1'b0, '1, 1'b1, 6'd0, '0);
        push_check('0);
        push_rule(4'd5, 1'b0, 1'b1, 32'h8000_0000, 1'b1, 6'd32, '0);
        push_check(32'h8000_0000);
        push_check(32'h8000_0001);
        settle();
        set_policy(POL_BAD2);
        push_check(32'h8000_0000);
        settle();
        set_policy(POL_BAD3);
        push_check(32'h8000_0000);
        push_op(OP_CLEAR);
        settle();

        // random phases
        set_policy(POL_DENY);
        run_random(250);
        settle();
        set_policy(POL_ALLOW);
        run_random(250);
        settle();
        set_policy(POL_BAD2);
        run_random(100);
        settle();
        set_policy(POL_ALLOW);
        gap_pct = 0;
        run_random(250);
        settle();
        gap_pct = 32;
        set_policy(POL_DENY);
        run_random(125);
        while (pending_cmds.size() > 60) @(negedge i_clk);
        hold_sender = 1'b1;
        while (verdicts_due.size() != 0 || busy || start) @(negedge i_clk);
        hold_sender = 1'b0;
        run_random(125);
        settle();
        set_policy(POL_BAD3);
        run_random(100);
        settle();
        set_policy(POL_ALLOW);
        run_random(250);
        settle();

        if (fault_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
